>>> hw/rtl/b58enc_pkg.sv
// Shared types, constants and the digit-to-character map of the base58 encoder.
// Used by every module of the encoder but the RAM; depends on nothing else.
package b58enc_pkg;

	localparam int MAX_BYTES_DEF   = 32;
	localparam int DIGIT_COUNT_DEF = 45;
	localparam int RESULT_LIMIT    = 45;
	localparam int PROD_W          = $clog2(RESULT_LIMIT + 1);

	localparam int DIGIT_W = 6;
	localparam int CARRY_W = 9;
	localparam int CHAR_W  = 7;
	localparam int SUM_W   = DIGIT_W + 8;
	localparam int RECIP_W = 15;
	localparam int RECIP_SHIFT = 20;

	// Reciprocal of 58 scaled by 2**20 and rounded up.
	localparam logic [RECIP_W-1:0] RECIP_58 = 15'd18079;

	localparam logic [CHAR_W-1:0] ONE_CHAR = 7'd49;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_ONES,
		ST_SCAN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic              push;
		logic              flush;
		logic [CHAR_W-1:0] code;
	} emit_ctl_t;

	function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] digit);
		logic [CHAR_W-1:0] d7;
		d7 = {1'b0, digit};
		case (digit) inside
			[6'd0 : 6'd8]:   b58_char = d7 + 7'd49;
			[6'd9 : 6'd16]:  b58_char = d7 + 7'd56;
			[6'd17 : 6'd21]: b58_char = d7 + 7'd57;
			[6'd22 : 6'd32]: b58_char = d7 + 7'd58;
			[6'd33 : 6'd43]: b58_char = d7 + 7'd64;
			[6'd44 : 6'd57]: b58_char = d7 + 7'd65;
			default:         b58_char = 7'd122;
		endcase
	endfunction

endpackage

>>> hw/rtl/b58enc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the base58 digit store; depends on nothing else.
module b58enc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 45
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/b58enc_step.sv
// Shared arithmetic unit: one digit step of digits*256 + carry in base 58.
// Depends on b58enc_pkg.
module b58enc_step (
	input  logic [b58enc_pkg::CARRY_W-1:0] carry_in,
	input  logic [b58enc_pkg::DIGIT_W-1:0] digit_in,
	output logic [b58enc_pkg::DIGIT_W-1:0] digit_out,
	output logic [b58enc_pkg::CARRY_W-1:0] carry_out
);
	import b58enc_pkg::*;

	localparam int PRODUCT_W = SUM_W + RECIP_W;

	logic [SUM_W-1:0]     sum;
	logic [PRODUCT_W-1:0] product;
	logic [CARRY_W-1:0]   quot;
	logic [SUM_W:0]       quot58;
	logic [SUM_W:0]       rem;

	// The quotient comes from a multiplication by the reciprocal of 58,
	// and the remainder from a shift-and-subtract multiple of the quotient.
	assign sum     = {digit_in, 8'b0} + SUM_W'(carry_in);
	assign product = PRODUCT_W'(sum) * PRODUCT_W'(RECIP_58);
	assign quot    = product[RECIP_SHIFT +: CARRY_W];
	assign quot58  = (SUM_W+1)'({quot, 6'b0}) - (SUM_W+1)'({quot, 2'b0})
		- (SUM_W+1)'({quot, 1'b0});
	assign rem     = {1'b0, sum} - quot58;

	assign digit_out = rem[DIGIT_W-1:0];
	assign carry_out = quot;

endmodule

>>> hw/rtl/b58enc_emit.sv
// Output stage: holds one character back so that the final one can be marked.
// Depends on b58enc_pkg.
module b58enc_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  b58enc_pkg::emit_ctl_t         ctl,
	input  logic                          ovf,
	output logic                          char_valid,
	output logic [b58enc_pkg::CHAR_W-1:0] char_code,
	output logic                          last_char,
	output logic                          overflow
);
	import b58enc_pkg::*;

	logic              pend_valid_q;
	logic [CHAR_W-1:0] pend_code_q;
	logic              valid_q;
	logic [CHAR_W-1:0] code_q;
	logic              last_q;
	logic              ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			valid_q <= pend_valid_q && (ctl.push || ctl.flush);
			if (ctl.push) begin
				pend_valid_q <= 1'b1;
			end else if (ctl.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			pend_code_q <= ctl.code;
		end
		if (ctl.push || ctl.flush) begin
			code_q <= pend_code_q;
			last_q <= ctl.flush;
			ovf_q  <= ovf;
		end
	end

	assign char_valid = valid_q;
	assign char_code  = code_q;
	assign last_char  = valid_q && last_q;
	assign overflow   = ovf_q;

endmodule

>>> hw/rtl/base58_encoder_core.sv
// Base58 encoder top level: sequencer, digit store, step unit and output stage.
// A leading zero byte is counted and not folded; any other byte is folded into the store,
// one digit per cycle through the shared step unit, before start is taken again.
// On the final byte the characters follow one per cycle, with a gap for each
// skipped leading zero digit and a gap between the ones and the scan; the final
// character is marked at the flush. Reset clears all sequencer control state.
module base58_encoder_core #(
	parameter int MAX_BYTES   = b58enc_pkg::MAX_BYTES_DEF,
	parameter int DIGIT_COUNT = b58enc_pkg::DIGIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          char_valid,
	output logic [b58enc_pkg::CHAR_W-1:0] char_code,
	output logic                          last_char,
	output logic                          overflow
);
	import b58enc_pkg::*;

	localparam int BC_W = $clog2(MAX_BYTES + 1);
	localparam int AW   = $clog2(DIGIT_COUNT);

	seq_state_t state_q, state_d;

	logic [BC_W-1:0]    byte_cnt_q;
	logic [BC_W-1:0]    zero_cnt_q;
	logic [BC_W-1:0]    ones_cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic               seen_q;
	logic               ovf_q;
	logic               first_q;
	logic               last_q;
	logic               lead_q;
	logic [CARRY_W-1:0] carry_q;
	logic [AW-1:0]      idx_q;

	logic               take;
	logic               room;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [DIGIT_W-1:0] ram_rdata;
	logic [DIGIT_W-1:0] step_in;
	logic [DIGIT_W-1:0] step_digit;
	logic [CARRY_W-1:0] step_carry;
	emit_ctl_t          ctl;

	assign busy = (state_q != ST_IDLE);
	assign take = start && !busy;
	assign room = (byte_cnt_q != BC_W'(MAX_BYTES));

	// The first fold of a message sees an all-zero store and writes every entry.
	assign step_in = first_q ? '0 : ram_rdata;

	b58enc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(DIGIT_COUNT)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(step_digit),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	b58enc_step u_step (
		.carry_in (carry_q),
		.digit_in (step_in),
		.digit_out(step_digit),
		.carry_out(step_carry)
	);

	b58enc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.ovf       (ovf_q),
		.char_valid(char_valid),
		.char_code (char_code),
		.last_char (last_char),
		.overflow  (overflow)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (room && (seen_q || data_byte != 8'd0)) begin
						state_d   = ST_FOLD;
						ram_re    = 1'b1;
						ram_raddr = AW'(DIGIT_COUNT - 1);
					end else if (last_byte) begin
						state_d = ST_ONES;
					end
				end
			end
			ST_FOLD: begin
				ram_we = 1'b1;
				if (idx_q == '0) begin
					state_d = last_q ? ST_ONES : ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_q - AW'(1);
				end
			end
			ST_ONES: begin
				if (ones_cnt_q != zero_cnt_q && prod_q != PROD_W'(RESULT_LIMIT)) begin
					ctl.push = 1'b1;
					ctl.code = ONE_CHAR;
				end else if (seen_q && prod_q != PROD_W'(RESULT_LIMIT)) begin
					state_d   = ST_SCAN;
					ram_re    = 1'b1;
					ram_raddr = '0;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_SCAN: begin
				if (!(lead_q && ram_rdata == '0)) begin
					ctl.push = 1'b1;
					ctl.code = b58_char(ram_rdata);
				end
				if (idx_q == AW'(DIGIT_COUNT - 1)
						|| (ctl.push && prod_q == PROD_W'(RESULT_LIMIT - 1))) begin
					state_d = ST_FLUSH;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_q + AW'(1);
				end
			end
			ST_FLUSH: begin
				ctl.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			zero_cnt_q <= '0;
			ones_cnt_q <= '0;
			prod_q     <= '0;
			seen_q     <= 1'b0;
			ovf_q      <= 1'b0;
			first_q    <= 1'b0;
			last_q     <= 1'b0;
			lead_q     <= 1'b0;
			carry_q    <= '0;
			idx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (room) begin
							byte_cnt_q <= byte_cnt_q + BC_W'(1);
							if (!seen_q && data_byte == 8'd0) begin
								zero_cnt_q <= zero_cnt_q + BC_W'(1);
							end else begin
								seen_q  <= 1'b1;
								first_q <= !seen_q;
								carry_q <= CARRY_W'(data_byte);
								idx_q   <= AW'(DIGIT_COUNT - 1);
								last_q  <= last_byte;
							end
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_FOLD: begin
					carry_q <= step_carry;
					if (idx_q != '0) begin
						idx_q <= idx_q - AW'(1);
					end
				end
				ST_ONES: begin
					if (ctl.push) begin
						ones_cnt_q <= ones_cnt_q + BC_W'(1);
						prod_q     <= prod_q + PROD_W'(1);
					end else begin
						idx_q  <= '0;
						lead_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (ctl.push) begin
						prod_q <= prod_q + PROD_W'(1);
						lead_q <= 1'b0;
					end
					idx_q <= idx_q + AW'(1);
				end
				ST_FLUSH: begin
					byte_cnt_q <= '0;
					zero_cnt_q <= '0;
					ones_cnt_q <= '0;
					prod_q     <= '0;
					seen_q     <= 1'b0;
					ovf_q      <= 1'b0;
				end
				default: begin
					seen_q <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_byte_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= BC_W'(MAX_BYTES))
		else $error("byte count passed its limit");

	a_fold_after_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> seen_q)
		else $error("fold without a nonzero byte");

	a_drop_sets_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !room) |=> ovf_q)
		else $error("dropped byte did not raise overflow");

	a_last_marks_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> char_valid)
		else $error("final mark outside a transfer");
`endif

endmodule
